// File: hdl/lsts_pkg.sv
// ----------------------------------------------------------------------------
// lsts_pkg
// Shared types and constants of the lazy segment tree block: request and
// result items, datapath operations, controller/datapath command and status.
// ----------------------------------------------------------------------------
package lsts_pkg;

  localparam int POS_W         = 11;
  localparam int DATA_W        = 32;
  localparam int LEAVES_DEF    = 1024;
  localparam int SUM_WIDTH_DEF = 32;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic        [POS_W-1:0]  range_low;
    logic        [POS_W-1:0]  range_high;
    logic signed [DATA_W-1:0] delta;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_sum;
    logic                     range_error;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_VISIT,
    OP_NODE,
    OP_PUSH1,
    OP_PUSH2,
    OP_PUSH3,
    OP_DESC,
    OP_RET,
    OP_PULL1,
    OP_PULL2,
    OP_PULL3,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cfg_we;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_bad;
    logic in_add;
    logic full;
    logic tag_zero;
    logic sp_zero;
    logic top_two;
    logic is_add;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hdl/lsts_ctrl.sv
// ----------------------------------------------------------------------------
// lsts_ctrl
// Sequencer of the tree walk: clear pass, request intake, node visit, tag
// push, descent, return with sum pull, and result hand-off.
// ----------------------------------------------------------------------------
module lsts_ctrl
  import lsts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      cfg_valid,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd,
  output logic      in_stall,
  output logic      cfg_ready
);

  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_VISIT = 13'b0000000000100,
    ST_NODE  = 13'b0000000001000,
    ST_PUSH1 = 13'b0000000010000,
    ST_PUSH2 = 13'b0000000100000,
    ST_PUSH3 = 13'b0000001000000,
    ST_DESC  = 13'b0000010000000,
    ST_RET   = 13'b0000100000000,
    ST_PULL1 = 13'b0001000000000,
    ST_PULL2 = 13'b0010000000000,
    ST_PULL3 = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    cmd.cfg_we = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.cfg_we = cfg_valid;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (!sts.in_bad) begin
            state_nxt = ST_VISIT;
          end else if (!sts.in_add) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_VISIT: begin
        cmd.op    = OP_VISIT;
        state_nxt = ST_NODE;
      end
      ST_NODE: begin
        cmd.op = OP_NODE;
        if (sts.full) begin
          state_nxt = ST_RET;
        end else if (sts.tag_zero) begin
          state_nxt = ST_DESC;
        end else begin
          state_nxt = ST_PUSH1;
        end
      end
      ST_PUSH1: begin
        cmd.op    = OP_PUSH1;
        state_nxt = ST_PUSH2;
      end
      ST_PUSH2: begin
        cmd.op    = OP_PUSH2;
        state_nxt = ST_PUSH3;
      end
      ST_PUSH3: begin
        cmd.op    = OP_PUSH3;
        state_nxt = ST_DESC;
      end
      ST_DESC: begin
        cmd.op    = OP_DESC;
        state_nxt = ST_VISIT;
      end
      ST_RET: begin
        cmd.op = OP_RET;
        if (sts.sp_zero) begin
          state_nxt = sts.is_add ? ST_IDLE : ST_DONE;
        end else if (sts.top_two) begin
          state_nxt = ST_VISIT;
        end else if (sts.is_add) begin
          state_nxt = ST_PULL1;
        end
      end
      ST_PULL1: begin
        cmd.op    = OP_PULL1;
        state_nxt = ST_PULL2;
      end
      ST_PULL2: begin
        cmd.op    = OP_PULL2;
        state_nxt = ST_PULL3;
      end
      ST_PULL3: begin
        cmd.op    = OP_PULL3;
        state_nxt = ST_RET;
      end
      ST_DONE: begin
        cmd.op = OP_DONE;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

`ifndef SYNTHESIS
  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |=> state_r == ST_CLEAR || state_r == ST_IDLE)
    else $error("clear pass left to a state other than idle");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !in_stall)
    else $error("size write open outside idle");
`endif

endmodule

// File: hdl/lsts_dp.sv
// ----------------------------------------------------------------------------
// lsts_dp
// Datapath: node sum and pending tag memories, walk stack, current node
// registers, tag and length products, query accumulator, result register.
// ----------------------------------------------------------------------------
module lsts_dp
  import lsts_pkg::*;
#(
  parameter int LEAVES    = LEAVES_DEF,
  parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  output dp_sts_t          sts,
  input  in_item_t         in_data,
  input  logic [POS_W-1:0] cfg_data,
  output out_item_t        out_data,
  output logic             out_valid,
  input  logic             out_stall
);

  localparam int NODES     = 4 * LEAVES;
  localparam int IDW       = $clog2(NODES);
  localparam int STK_DEPTH = $clog2(LEAVES) + 1;
  localparam int SPW       = $clog2(STK_DEPTH + 1);
  localparam int STKIW     = $clog2(STK_DEPTH);
  localparam int SW        = SUM_WIDTH;
  localparam logic [POS_W-1:0] SIZE_RST = POS_W'((LEAVES < 1024) ? LEAVES : 1024);
  localparam logic [POS_W-1:0] SIZE_MAX = POS_W'((LEAVES < 2047) ? LEAVES : 2047);
  localparam logic [IDW-1:0]   CLR_LAST = IDW'(NODES - 1);

  typedef struct packed {
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    logic [IDW-1:0]   id;
    logic             two;
  } frame_t;

  logic [SW-1:0] sum_mem [NODES];
  logic [SW-1:0] pend_mem[NODES];

  logic [POS_W-1:0] size_r, lo_r, hi_r, a_r, b_r;
  logic [IDW-1:0]   id_r, clr_r;
  logic             is_add_r, err_r;
  logic [SW-1:0]    delta_r, acc_r, prod_r, prodl_r, prodr_r, tag_r, left_r;
  logic [SW-1:0]    sum_q, pend_q;
  logic [SPW-1:0]   sp_r;
  frame_t           stk_r[STK_DEPTH];
  out_item_t        out_r;
  logic             out_valid_r;

  logic [POS_W-1:0] mid, len, lenl, lenr, mid_t, cfg_clamp;
  logic [IDW-1:0]   id2, id2p1, top_id2p1;
  logic [SPW-1:0]   sp_m1;
  frame_t           top;
  logic             full, out_free;
  logic [SW+POS_W-1:0] p_node, p_left, p_right;

  logic             rd_en, sum_we, pend_we;
  logic [IDW-1:0]   rd_addr, sum_wa, pend_wa;
  logic [SW-1:0]    sum_wd, pend_wd;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign len       = hi_r - lo_r + POS_W'(1);
  assign lenl      = mid - lo_r + POS_W'(1);
  assign lenr      = hi_r - mid;
  assign full      = (lo_r == a_r) && (hi_r == b_r);
  assign id2       = {id_r[IDW-2:0], 1'b0};
  assign id2p1     = {id_r[IDW-2:0], 1'b1};
  assign sp_m1     = sp_r - SPW'(1);
  assign top       = stk_r[sp_m1[STKIW-1:0]];
  assign mid_t     = top.lo + ((top.hi - top.lo) >> 1);
  assign top_id2p1 = {top.id[IDW-2:0], 1'b1};
  assign out_free  = !out_valid_r || !out_stall;
  assign p_node    = len * delta_r;
  assign p_left    = lenl * pend_q;
  assign p_right   = lenr * pend_q;

  always_comb begin
    cfg_clamp = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamp = POS_W'(1);
    end else if (cfg_data > SIZE_MAX) begin
      cfg_clamp = SIZE_MAX;
    end
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = id_r;
    sum_we  = 1'b0;
    sum_wa  = id_r;
    sum_wd  = '0;
    pend_we = 1'b0;
    pend_wa = id_r;
    pend_wd = '0;
    case (cmd.op)
      OP_CLEAR: begin
        sum_we  = 1'b1;
        sum_wa  = clr_r;
        pend_we = 1'b1;
        pend_wa = clr_r;
      end
      OP_VISIT: begin
        rd_en = 1'b1;
      end
      OP_NODE: begin
        if (full && is_add_r) begin
          sum_we  = 1'b1;
          sum_wd  = sum_q + prod_r;
          pend_we = 1'b1;
          pend_wd = pend_q + delta_r;
        end else if (!full) begin
          rd_en   = 1'b1;
          rd_addr = id2;
        end
      end
      OP_PUSH1: begin
        sum_we  = 1'b1;
        sum_wa  = id2;
        sum_wd  = sum_q + prodl_r;
        pend_we = 1'b1;
        pend_wa = id2;
        pend_wd = pend_q + tag_r;
        rd_en   = 1'b1;
        rd_addr = id2p1;
      end
      OP_PUSH2: begin
        sum_we  = 1'b1;
        sum_wa  = id2p1;
        sum_wd  = sum_q + prodr_r;
        pend_we = 1'b1;
        pend_wa = id2p1;
        pend_wd = pend_q + tag_r;
      end
      OP_PUSH3: begin
        pend_we = 1'b1;
      end
      OP_PULL1: begin
        rd_en   = 1'b1;
        rd_addr = id2;
      end
      OP_PULL2: begin
        rd_en   = 1'b1;
        rd_addr = id2p1;
      end
      OP_PULL3: begin
        sum_we = 1'b1;
        sum_wd = left_r + sum_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    if (rd_en) begin
      sum_q <= sum_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    if (rd_en) begin
      pend_q <= pend_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RST;
      clr_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        size_r <= cfg_clamp;
      end
      if (cmd.op == OP_CLEAR) begin
        clr_r <= clr_r + IDW'(1);
      end
      if (cmd.op == OP_LOAD) begin
        sp_r <= '0;
      end else if (cmd.op == OP_DESC) begin
        sp_r <= sp_r + SPW'(1);
      end else if (cmd.op == OP_RET && sp_r != '0 && !top.two) begin
        sp_r <= sp_m1;
      end
      if (cmd.op == OP_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        lo_r     <= POS_W'(1);
        hi_r     <= size_r;
        id_r     <= IDW'(1);
        a_r      <= in_data.range_low;
        b_r      <= in_data.range_high;
        is_add_r <= (in_data.cmd == CMD_ADD);
        delta_r  <= SW'(in_data.delta);
        err_r    <= sts.in_bad;
        acc_r    <= '0;
      end
      OP_VISIT: begin
        prod_r <= SW'(p_node);
      end
      OP_NODE: begin
        if (full && !is_add_r) begin
          acc_r <= acc_r + sum_q;
        end
        if (!full) begin
          tag_r   <= pend_q;
          prodl_r <= SW'(p_left);
          prodr_r <= SW'(p_right);
        end
      end
      OP_DESC: begin
        stk_r[sp_r[STKIW-1:0]] <= '{lo: lo_r, hi: hi_r, a: a_r, b: b_r, id: id_r,
                                    two: (a_r <= mid) && (b_r > mid)};
        if (b_r <= mid) begin
          hi_r <= mid;
          id_r <= id2;
        end else if (a_r > mid) begin
          lo_r <= mid + POS_W'(1);
          id_r <= id2p1;
        end else begin
          hi_r <= mid;
          id_r <= id2;
          b_r  <= mid;
        end
      end
      OP_RET: begin
        if (sp_r != '0) begin
          if (top.two) begin
            // revisit frame for its right child
            stk_r[sp_m1[STKIW-1:0]].two <= 1'b0;
            lo_r <= mid_t + POS_W'(1);
            hi_r <= top.hi;
            id_r <= top_id2p1;
            a_r  <= mid_t + POS_W'(1);
            b_r  <= top.b;
          end else begin
            lo_r <= top.lo;
            hi_r <= top.hi;
            id_r <= top.id;
          end
        end
      end
      OP_PULL2: begin
        left_r <= sum_q;
      end
      OP_DONE: begin
        if (out_free) begin
          out_r.range_sum   <= err_r ? '0 : DATA_W'($signed(acc_r));
          out_r.range_error <= err_r;
        end
      end
      default: begin
        left_r <= left_r;
      end
    endcase
  end

  always_comb begin
    sts.clear_last = (clr_r == CLR_LAST);
    sts.in_bad     = (in_data.range_low == '0) ||
                     (in_data.range_low > in_data.range_high) ||
                     (in_data.range_high > size_r);
    sts.in_add     = (in_data.cmd == CMD_ADD);
    sts.full       = full;
    sts.tag_zero   = (pend_q == '0);
    sts.sp_zero    = (sp_r == '0);
    sts.top_two    = top.two;
    sts.is_add     = is_add_r;
    sts.out_free   = out_free;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STK_DEPTH))
    else $error("walk stack overflow");
  a_desc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_DESC |-> sp_r < SPW'(STK_DEPTH))
    else $error("descent with full walk stack");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_DONE))
    else $error("result raised outside hand-off step");
`endif

endmodule

// File: hdl/lazy_segment_tree_range_add_sum.sv
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_add_sum
// Lazy segment tree over positions 1..size_in_use with range add and range sum.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : request channel (valid/stall). cmd 0 adds delta over
//            [range_low, range_high]; cmd 1 asks for the range sum.
//   out_*  : result channel (valid/stall), one result per query, none per add.
//   cfg_*  : write of size_in_use (valid/ready), taken only while idle;
//            0 stores 1, values above LEAVES store LEAVES.
// Timing: one request at a time. Each visited node takes a visit step and a
// node step, plus a descent step; a pending tag push adds steps PUSH1 to
// PUSH3, and a parent sum update on the way back adds steps PULL1 to PULL3.
// A request whose range the root covers needs no descent; an invalid add
// starts no walk. The step sequence is set by the single read port of the
// node sum and tag memories.
// Reset: a clearing pass writes zero to all 4*LEAVES nodes, one per cycle,
// with in_stall high; size_in_use returns to min(1024, LEAVES).
// A stalled result holds in the output register; the next request is
// still taken, and its own result waits until that register frees up.
// Invalid ranges: adds are dropped, queries return 0 with range_error set.
// ----------------------------------------------------------------------------
module lazy_segment_tree_range_add_sum
  import lsts_pkg::*;
#(
  parameter int LEAVES    = LEAVES_DEF,
  parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  lsts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  lsts_dp #(
    .LEAVES    (LEAVES),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

// File: tb/lsts_checker.sv
// ----------------------------------------------------------------------------
// lsts_checker
// Watches the request, result and size write channels of the lazy segment
// tree, keeps its own copy of the tree, and checks every result in order.
// ----------------------------------------------------------------------------
module lsts_checker
  import lsts_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending_count,
  output int               query_count,
  output int               add_count
);

  localparam int NODES = 4 * LEAVES;

  logic [31:0] tree_sum [NODES];
  logic [31:0] tree_tag [NODES];
  int unsigned leaf_count;
  out_item_t   sum_queue [$];

  function automatic void tag_node(int unsigned id, int unsigned len, logic [31:0] d);
    if (id < NODES) begin
      tree_sum[id] = tree_sum[id] + len * d;
      tree_tag[id] = tree_tag[id] + d;
    end
  endfunction

  function automatic void push_down(int unsigned lo, int unsigned hi, int unsigned id);
    int unsigned mid;
    mid = lo + ((hi - lo) >> 1);
    if (id < NODES && tree_tag[id] != 0) begin
      tag_node(2 * id, mid - lo + 1, tree_tag[id]);
      tag_node(2 * id + 1, hi - mid, tree_tag[id]);
      tree_tag[id] = 0;
    end
  endfunction

  task automatic tree_add(int unsigned lo, int unsigned hi, int unsigned id,
                          int unsigned a, int unsigned b, logic [31:0] d);
    int unsigned mid;
    if (id >= NODES) return;
    if (lo == a && hi == b) begin
      tag_node(id, hi - lo + 1, d);
      return;
    end
    mid = lo + ((hi - lo) >> 1);
    push_down(lo, hi, id);
    if (b <= mid) tree_add(lo, mid, 2 * id, a, b, d);
    else if (a > mid) tree_add(mid + 1, hi, 2 * id + 1, a, b, d);
    else begin
      tree_add(lo, mid, 2 * id, a, mid, d);
      tree_add(mid + 1, hi, 2 * id + 1, mid + 1, b, d);
    end
    if (2 * id + 1 < NODES) tree_sum[id] = tree_sum[2 * id] + tree_sum[2 * id + 1];
  endtask

  function automatic logic [31:0] tree_query(int unsigned lo, int unsigned hi,
                                             int unsigned id, int unsigned a,
                                             int unsigned b);
    int unsigned mid;
    if (id >= NODES) return 0;
    if (lo == a && hi == b) return tree_sum[id];
    mid = lo + ((hi - lo) >> 1);
    push_down(lo, hi, id);
    if (b <= mid) return tree_query(lo, mid, 2 * id, a, b);
    if (a > mid) return tree_query(mid + 1, hi, 2 * id + 1, a, b);
    return tree_query(lo, mid, 2 * id, a, mid) +
           tree_query(mid + 1, hi, 2 * id + 1, mid + 1, b);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    fail_count++;
  endtask

  assign pending_count = sum_queue.size();

  always @(posedge clk) begin
    out_item_t   want;
    int unsigned a, b, v;
    logic        bad;
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        tree_sum[i] = 0;
        tree_tag[i] = 0;
      end
      leaf_count = (LEAVES < 1024) ? LEAVES : 1024;
      sum_queue.delete();
      fail_count = 0;
      query_count = 0;
      add_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sum_queue.size() == 0) begin
          report("unexpected result", out_data.range_sum, 0);
        end else begin
          want = sum_queue.pop_front();
          if (out_data.range_sum !== want.range_sum)
            report("range_sum", out_data.range_sum, want.range_sum);
          if (out_data.range_error !== want.range_error)
            report("range_error", 32'(out_data.range_error), 32'(want.range_error));
        end
      end
      if (in_valid && !in_stall) begin
        a = 32'(in_data.range_low);
        b = 32'(in_data.range_high);
        bad = (a < 1) || (a > b) || (b > leaf_count);
        if (in_data.cmd == CMD_ADD) begin
          add_count++;
          if (!bad) tree_add(1, leaf_count, 1, a, b, in_data.delta);
        end else begin
          query_count++;
          want.range_error = bad;
          want.range_sum = bad ? 32'sd0 : tree_query(1, leaf_count, 1, a, b);
          sum_queue.insert(sum_queue.size(), want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        v = 32'(cfg_data);
        if (v < 1) v = 1;
        if (v > LEAVES) v = LEAVES;
        leaf_count = v;
      end
    end
  end

endmodule

// File: tb/lazy_segment_tree_range_add_sum_tb.sv
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_add_sum_tb
// Drives directed and random range adds and sum queries under several tree
// sizes with random gaps and stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module lazy_segment_tree_range_add_sum_tb;
  import lsts_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [POS_W-1:0] cfg_data = '0;
  int               fail_count, pending_count, query_count, add_count;
  int               cycle_count = 0;
  int               hold_seq = 0;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_LEN    = 600;

  lazy_segment_tree_range_add_sum dut (.*);

  lsts_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stall per result, plus a long hold when requested
  initial begin
    int w;
    int seen;
    seen = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_seq != seen) begin
        seen = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk iff (out_valid && !out_stall) || hold_seq != seen);
      end
    end
  end

  int unsigned cur_size = 1024;
  bit          no_gaps = 1'b0;

  task automatic send(logic cmd, int unsigned lo, int unsigned hi, logic [31:0] d);
    int w;
    in_valid <= 1'b1;
    in_data.cmd <= cmd;
    in_data.range_low <= POS_W'(lo);
    in_data.range_high <= POS_W'(hi);
    in_data.delta <= d;
    @(posedge clk iff !in_stall);
    // gap before the next request
    w = no_gaps ? 0 : $urandom_range(0, 11);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk iff pending_count == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_size(int unsigned v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= POS_W'(v);
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    if (v < 1) cur_size = 1;
    else if (v > 1024) cur_size = 1024;
    else cur_size = v;
  endtask

  task automatic random_item();
    int unsigned lo, hi, r, span;
    logic [31:0] d;
    r = $urandom_range(0, 19);
    span = (cur_size > 16 && $urandom_range(0, 1)) ? 16 : cur_size;
    lo = $urandom_range(1, cur_size);
    hi = $urandom_range(lo, (lo + span - 1 > cur_size) ? cur_size : lo + span - 1);
    if ($urandom_range(0, 7) == 0) begin
      lo = 1;
      hi = cur_size;
    end
    d = $urandom();
    if (r == 0) begin
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(0, 2047);
    end else if (r == 1) begin
      hi = cur_size + $urandom_range(1, 2047 - cur_size);
    end else if (r == 2) begin
      lo = 0;
    end
    send($urandom_range(0, 1) ? CMD_QUERY : CMD_ADD, lo, hi, d);
  endtask

  initial begin
    int unsigned sizes [6] = '{1024, 1, 2, 37, 0, 2047};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, full range, empty and invalid ranges
    send(CMD_QUERY, 1, 1024, 0);
    send(CMD_ADD, 1, 1024, 32'h7fffffff);
    send(CMD_QUERY, 1, 1024, 0);
    send(CMD_ADD, 1, 1, 32'h80000000);
    send(CMD_ADD, 1024, 1024, 32'hffffffff);
    send(CMD_QUERY, 1, 1, 0);
    send(CMD_QUERY, 1024, 1024, 0);
    send(CMD_ADD, 300, 700, 32'h12345678);
    send(CMD_QUERY, 1, 512, 0);
    send(CMD_QUERY, 513, 1024, 0);
    send(CMD_QUERY, 400, 401, 0);
    send(CMD_ADD, 0, 5, 32'h1);
    send(CMD_QUERY, 0, 5, 0);
    send(CMD_ADD, 9, 8, 32'h1);
    send(CMD_QUERY, 9, 8, 0);
    send(CMD_ADD, 5, 1025, 32'h1);
    send(CMD_QUERY, 5, 2047, 0);
    send(CMD_QUERY, 2047, 2047, 32'hffffffff);
    send(CMD_QUERY, 1, 1024, 0);
    // long receiver hold while the sender keeps offering
    hold_seq++;
    no_gaps = 1'b1;
    repeat (12) random_item();
    no_gaps = 1'b0;
    drain();
    foreach (sizes[k]) begin
      set_size(sizes[k]);
      repeat (150) random_item();
      // pause the sender until all results are in
      drain();
      for (int j = 0; j < 30; j++) random_item();
    end
    set_size(1024);
    repeat (60) random_item();
    drain();
    $display("covered %0d adds and %0d queries over six tree sizes", add_count,
             query_count);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
